// ===== rtl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue package
// Shared types and codes for the ring-store double-ended queue.
// ---------------------------------------------------------------------------
package dq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_dq_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_en;

endpackage

// ===== rtl/dq_store.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue entry store
// Single-port-write, single-port-read ring memory with a registered read.
// ---------------------------------------------------------------------------
module dq_store #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic                             i_clk,
    input  dq_pkg::t_mem_en                  i_en,
    input  logic [IW-1:0]                    i_waddr,
    input  logic signed [dq_pkg::WORD_W-1:0] i_wdata,
    input  logic [IW-1:0]                    i_raddr,
    output logic signed [dq_pkg::WORD_W-1:0] o_rdata
);

    logic signed [dq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic signed [dq_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dq_ctrl.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue controller
// Keeps the front index and entry count, drives the store and the output
// register, and sequences list commands one entry per cycle unless stalled.
// ---------------------------------------------------------------------------
module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_command,
    input  logic signed [dq_pkg::WORD_W-1:0] i_push_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [dq_pkg::WORD_W-1:0] o_entry_value,
    output logic [1:0]                       o_status,
    output logic                             o_last_of_run,
    output dq_pkg::t_mem_en                  o_mem_en,
    output logic [IW-1:0]                    o_waddr,
    output logic signed [dq_pkg::WORD_W-1:0] o_wdata,
    output logic [IW-1:0]                    o_raddr,
    input  logic signed [dq_pkg::WORD_W-1:0] i_rdata
);

    localparam logic [IW:0]   DEPTH_S = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

    dq_pkg::t_dq_state r_state, n_state;
    logic [IW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_offs, n_offs;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    logic signed [dq_pkg::WORD_W-1:0] r_out_value, n_out_value;
    dq_pkg::t_status   r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    logic out_free;
    logic accept;
    logic full;
    logic empty;

    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [IW-1:0] offs);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[IW-1:0];
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == dq_pkg::S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == DEPTH_C);
    assign empty      = (r_count == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::S_IDLE: begin
                if (accept && dq_pkg::t_cmd'(i_command) == dq_pkg::CMD_LIST && !empty) begin
                    n_state = dq_pkg::S_LIST;
                end
            end
            dq_pkg::S_LIST: begin
                if (out_free && r_pend_last) begin
                    n_state = dq_pkg::S_IDLE;
                end
            end
            default: n_state = dq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_offs       = r_offs;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_mem_en     = '0;
        o_waddr      = '0;
        o_wdata      = i_push_value;
        o_raddr      = '0;
        case (r_state)
            dq_pkg::S_IDLE: begin
                if (accept) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = dq_pkg::ST_OK;
                    n_out_last   = 1'b1;
                    case (dq_pkg::t_cmd'(i_command))
                        dq_pkg::CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_out_status = dq_pkg::ST_FULL;
                            end else begin
                                n_front        = (r_front == '0) ? LAST_IX : r_front - 1'b1;
                                o_mem_en.wr_en = 1'b1;
                                o_waddr        = n_front;
                                n_count        = r_count + 1'b1;
                            end
                        end
                        dq_pkg::CMD_PUSH_BACK: begin
                            if (full) begin
                                n_out_status = dq_pkg::ST_FULL;
                            end else begin
                                o_mem_en.wr_en = 1'b1;
                                o_waddr        = ring_pos(r_front, r_count[IW-1:0]);
                                n_count        = r_count + 1'b1;
                            end
                        end
                        dq_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                n_out_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                n_front = (r_count == CW'(1)) ? '0 :
                                          ring_pos(r_front, IW'(1));
                            end
                        end
                        dq_pkg::CMD_POP_BACK: begin
                            if (empty) begin
                                n_out_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                if (r_count == CW'(1)) begin
                                    n_front = '0;
                                end
                            end
                        end
                        dq_pkg::CMD_LIST: begin
                            if (empty) begin
                                n_out_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid    = r_out_valid && !i_out_ready;
                                o_mem_en.rd_en = 1'b1;
                                o_raddr        = r_front;
                                n_offs         = CW'(1);
                                n_pend_last    = (r_count == CW'(1));
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_out_ready;
                        end
                    endcase
                end
            end
            dq_pkg::S_LIST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = i_rdata;
                    n_out_status = dq_pkg::ST_OK;
                    n_out_last   = r_pend_last;
                    if (!r_pend_last) begin
                        o_mem_en.rd_en = 1'b1;
                        o_raddr        = ring_pos(r_front, r_offs[IW-1:0]);
                        n_pend_last    = (r_offs + 1'b1 == r_count);
                        n_offs         = r_offs + 1'b1;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dq_pkg::S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_offs      <= '0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_offs      <= n_offs;
            r_pend_last <= n_pend_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= LAST_IX)
        else $error("front index outside ring");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0))
        else $error("empty queue with nonzero front index");

    a_list_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dq_pkg::S_LIST) |-> (!o_in_ready && !o_mem_en.wr_en))
        else $error("input taken or store written during a list");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dq_pkg::S_LIST) |-> (r_count != '0 && r_offs <= r_count))
        else $error("list running past the stored entries");

endmodule

// ===== rtl/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words in a ring memory with push, pop
// and list commands.
// For push and pop, the status item appears in the cycle after acceptance.
// A list streams one entry per cycle while the output is not stalled; the
// first entry passes the memory's registered read and then the output
// register, and input is held off until the last entry is in that register.
// Reset clears the front index, the count and the output valid flag; the
// memory contents are not cleared.
// ---------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_command,
    input  logic signed [dq_pkg::WORD_W-1:0] i_push_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [dq_pkg::WORD_W-1:0] o_entry_value,
    output logic [1:0]                       o_status,
    output logic                             o_last_of_run
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dq_pkg::t_mem_en                  mem_en;
    logic [IW-1:0]                    waddr;
    logic [IW-1:0]                    raddr;
    logic signed [dq_pkg::WORD_W-1:0] wdata;
    logic signed [dq_pkg::WORD_W-1:0] rdata;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_value (o_entry_value),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run),
        .o_mem_en      (mem_en),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .i_rdata       (rdata)
    );

    dq_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
